/* hw/rtl/rcl_pkg.sv */
package rcl_pkg;

	localparam int COST_FIT_BIT  = 0;
	localparam int COST_DIS_BIT  = 1;
	localparam int COST_RATE_BIT = 2;
	localparam int COST_SSE_BIT  = 3;
	localparam int COST_SAD_BIT  = 4;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [4:0]  mask;
		logic [31:0] fit;
		logic [31:0] dis;
		logic [31:0] rate;
		logic [31:0] sse;
		logic [31:0] sad;
		logic [31:0] tag;
	} cand_t;

	typedef struct packed {
		logic [3:0] count;
		logic [3:0] slot;
		logic       error;
		cand_t      rec;
	} res_t;

	typedef struct packed {
		logic miss;
		logic win;
	} cmp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_READ
	} state_t;

	function automatic cmp_t rcl_beats(cand_t a, cand_t b);
		logic [4:0] m;
		cmp_t       r;
		m = a.mask & b.mask;
		r = '0;
		priority if (m[COST_FIT_BIT]) begin
			r.win = $signed(a.fit) > $signed(b.fit);
		end else if (m[COST_DIS_BIT]) begin
			r.win = a.dis < b.dis;
		end else if (m[COST_RATE_BIT]) begin
			r.win = a.rate < b.rate;
		end else if (m[COST_SSE_BIT]) begin
			r.win = a.sse < b.sse;
		end else if (m[COST_SAD_BIT]) begin
			r.win = a.sad < b.sad;
		end else begin
			r.miss = 1'b1;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ranked_candidate_list.sv */
// channel   | handshake                   | payload
// ----------+-----------------------------+---------------------------------------------
// item in   | start & !busy               | kind cost_mask fitness distortion rate
//           |                             | sse sad mode_tag index
// result    | done, one cycle, no stall   | count slot error out_mask out_fitness
//           |                             | out_distortion out_rate out_sse out_sad out_tag
// A read fetches the entry and raises done with it. Clear or an unknown kind raises done
// with no memory access. An insert into an empty list goes straight to the write; else it
// searches from the tail toward the head while it beats entries, shifts those behind its
// place down one slot, then writes and raises done. A dropped or failed insert skips shift
// and write. The entry memory does one read and one write per cycle. Reset empties the list
// at once, with no sweep. busy stays high until the last memory write of an insert; done
// may not be held off.
module ranked_candidate_list
	import rcl_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [4:0]         cost_mask,
	input  logic signed [31:0] fitness,
	input  logic [31:0]        distortion,
	input  logic [31:0]        rate,
	input  logic [31:0]        sse,
	input  logic [31:0]        sad,
	input  logic [31:0]        mode_tag,
	input  logic [2:0]         index,
	output logic               done,
	output logic [3:0]         count,
	output logic [3:0]         slot,
	output logic               error,
	output logic [4:0]         out_mask,
	output logic signed [31:0] out_fitness,
	output logic [31:0]        out_distortion,
	output logic [31:0]        out_rate,
	output logic [31:0]        out_sse,
	output logic [31:0]        out_sad,
	output logic [31:0]        out_tag
);

	localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY + 1) : 1;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [3:0] SLOT_DROP = 4'(CAPACITY);

	cand_t         in_rec;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	cand_t         mem_wdata, mem_rdata;
	res_t          res;

	assign in_rec.mask = cost_mask;
	assign in_rec.fit  = fitness;
	assign in_rec.dis  = distortion;
	assign in_rec.rate = rate;
	assign in_rec.sse  = sse;
	assign in_rec.sad  = sad;
	assign in_rec.tag  = mode_tag;

	rcl_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rcl_seq #(
		.CAPACITY(CAPACITY),
		.CW      (CW),
		.AW      (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.in_rec   (in_rec),
		.index    (index),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.done     (done),
		.res      (res)
	);

	assign count          = res.count;
	assign slot           = res.slot;
	assign error          = res.error;
	assign out_mask       = res.rec.mask;
	assign out_fitness    = res.rec.fit;
	assign out_distortion = res.rec.dis;
	assign out_rate       = res.rec.rate;
	assign out_sse        = res.rec.sse;
	assign out_sad        = res.rec.sad;
	assign out_tag        = res.rec.tag;

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither in progress nor finished");

	a_error_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (slot == SLOT_DROP && out_mask == '0))
		else $error("failed insert reports a slot or entry data");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_mask != '0) |-> (slot == '0 && !error))
		else $error("read result carries insert status");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("entry memory written while idle");

endmodule

/* hw/rtl/rcl_store.sv */
module rcl_store
	import rcl_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cand_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output cand_t         rdata
);

	cand_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/rcl_seq.sv */
module rcl_seq
	import rcl_pkg::*;
#(
	parameter int CAPACITY = 8,
	parameter int CW       = 4,
	parameter int AW       = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    kind,
	input  cand_t         in_rec,
	input  logic [2:0]    index,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output cand_t         mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  cand_t         mem_rdata,
	output logic          done,
	output res_t          res
);

	localparam int IW = (CW > 3) ? CW : 3;
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);
	localparam logic [3:0] SLOT_DROP = 4'(CAPACITY);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] ptr_q;
	logic          hit_q;
	cand_t         new_q;
	logic          done_q;
	res_t          res_q;

	cmp_t          cmp;
	logic [CW-1:0] pos_m1, pos_m2, ptr_m1, ptr_m2;
	logic [CW-1:0] last, cnt_inc, srch_p, place_p;
	logic          srch_more, drop, need_shift, shift_more;
	logic [IW-1:0] idx_ext;
	logic          idx_hit;
	logic          fin;
	res_t          res_d;

	assign cmp        = rcl_beats(new_q, mem_rdata);
	assign pos_m1     = pos_q - CW'(1);
	assign pos_m2     = pos_q - CW'(2);
	assign ptr_m1     = ptr_q - CW'(1);
	assign ptr_m2     = ptr_q - CW'(2);
	assign last       = (cnt_q < CAP_C) ? cnt_q : LAST_C;
	assign cnt_inc    = (cnt_q < CAP_C) ? cnt_q + CW'(1) : CAP_C;
	assign srch_more  = cmp.win && (pos_m1 != '0);
	assign srch_p     = cmp.win ? pos_m1 : pos_q;
	assign place_p    = (state_q == ST_IDLE) ? cnt_q : srch_p;
	assign drop       = (place_p == CAP_C);
	assign need_shift = (last > place_p);
	assign shift_more = (ptr_m1 > pos_q);
	assign idx_ext    = IW'(index);
	assign idx_hit    = idx_ext < IW'(cnt_q);
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign res        = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_INSERT: state_d = (cnt_q != '0) ? ST_SRCH_RD : ST_PUT;
						KIND_READ:   state_d = ST_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SRCH_RD: state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				priority if (cmp.miss) begin
					state_d = ST_IDLE;
				end else if (srch_more) begin
					state_d = ST_SRCH_CMP;
				end else if (drop) begin
					state_d = ST_IDLE;
				end else if (need_shift) begin
					state_d = ST_SHIFT_RD;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = shift_more ? ST_SHIFT_WR : ST_PUT;
			ST_PUT:      state_d = ST_IDLE;
			ST_READ:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = new_q;
		mem_re    = 1'b0;
		mem_raddr = pos_m1[AW-1:0];
		fin       = 1'b0;
		res_d     = '0;
		res_d.count = 4'(cnt_q);
		unique case (state_q)
			ST_IDLE: begin
				mem_raddr = idx_ext[AW-1:0];
				if (start) begin
					unique case (kind)
						KIND_INSERT: ;
						KIND_READ:   mem_re = 1'b1;
						KIND_CLEAR: begin
							fin         = 1'b1;
							res_d.count = '0;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_SRCH_RD: mem_re = 1'b1;
			ST_SRCH_CMP: begin
				mem_re    = srch_more;
				mem_raddr = pos_m2[AW-1:0];
				priority if (cmp.miss) begin
					fin         = 1'b1;
					res_d.error = 1'b1;
					res_d.slot  = SLOT_DROP;
				end else if (!srch_more && drop) begin
					fin        = 1'b1;
					res_d.slot = SLOT_DROP;
				end
			end
			ST_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_m1[AW-1:0];
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
				mem_wdata = mem_rdata;
				mem_re    = shift_more;
				mem_raddr = ptr_m2[AW-1:0];
			end
			ST_PUT: begin
				mem_we      = 1'b1;
				fin         = 1'b1;
				res_d.count = 4'(cnt_inc);
				res_d.slot  = 4'(pos_q);
			end
			ST_READ: begin
				fin = 1'b1;
				if (hit_q) begin
					res_d.rec = mem_rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_IDLE && start && kind == KIND_CLEAR) begin
				cnt_q <= '0;
			end else if (state_q == ST_PUT) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res_d;
		end
		unique case (state_q)
			ST_IDLE: begin
				new_q <= in_rec;
				pos_q <= cnt_q;
				ptr_q <= last;
				hit_q <= idx_hit;
			end
			ST_SRCH_CMP: begin
				pos_q <= srch_p;
				ptr_q <= last;
			end
			ST_SHIFT_WR: ptr_q <= ptr_m1;
			default: ;
		endcase
	end

endmodule
